/* rtl/hxt_pkg.sv */
`timescale 1ns / 1ps

package hxt_pkg;

  // Tile edge length in pixels.
  localparam int unsigned TileSize = 16;

  // Item operations.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_FILL  = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_SKIP  = 2'd2;

  // Parser phases.
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SUBENC = 4'd1;
  localparam logic [3:0] PH_RAW    = 4'd2;
  localparam logic [3:0] PH_ZLEN   = 4'd3;
  localparam logic [3:0] PH_ZSKIP  = 4'd4;
  localparam logic [3:0] PH_BG     = 4'd5;
  localparam logic [3:0] PH_FG     = 4'd6;
  localparam logic [3:0] PH_COUNT  = 4'd7;
  localparam logic [3:0] PH_SCOLOR = 4'd8;
  localparam logic [3:0] PH_GEO1   = 4'd9;
  localparam logic [3:0] PH_GEO2   = 4'd10;

  // Subencoding flag bits.
  localparam int unsigned SE_RAW   = 0;
  localparam int unsigned SE_BG    = 1;
  localparam int unsigned SE_FG    = 2;
  localparam int unsigned SE_SUBR  = 3;
  localparam int unsigned SE_COLSR = 4;
  localparam int unsigned SE_ZLO   = 5;
  localparam int unsigned SE_ZHI   = 6;

  // Pixel size codes.
  localparam logic [1:0] PSZ_8  = 2'd0;
  localparam logic [1:0] PSZ_16 = 2'd1;

  // Parser state.
  typedef struct packed {
    logic [3:0]  phase;
    logic [16:0] tile_x;
    logic [16:0] tile_y;
    logic [4:0]  tile_w;
    logic [4:0]  tile_h;
    logic [16:0] rect_right;
    logic [16:0] rect_bottom;
    logic [15:0] rect_left;
    logic [7:0]  sub_flags;
    logic [31:0] background;
    logic [31:0] foreground;
    logic [7:0]  subrects_left;
    logic [15:0] byte_counter;
    logic [31:0] partial;
    logic [7:0]  geo;
    logic [1:0]  px_last;
    logic [3:0]  pix_col;
    logic [3:0]  pix_row;
  } st_t;

  // One drawing command.
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [4:0]  fill_w;
    logic [4:0]  fill_h;
    logic [31:0] color;
    logic        rect_done;
  } res_t;

  // Clips a remaining span to one tile.
  function automatic logic [4:0] clip_dim(input logic [16:0] span);
    logic [4:0] d;
    if (span < 17'(TileSize)) begin
      d = span[4:0];
    end else begin
      d = 5'(TileSize);
    end
    return d;
  endfunction

endpackage

/* rtl/hxt_parse.sv */
`timescale 1ns / 1ps

module hxt_parse import hxt_pkg::*; (
  input  st_t         st,
  input  logic [1:0]  cfg_code,
  input  logic        op,
  input  logic [15:0] rect_x,
  input  logic [15:0] rect_y,
  input  logic [15:0] rect_w,
  input  logic [15:0] rect_h,
  input  logic [7:0]  data_byte,
  output st_t         st_nxt,
  output logic        res_valid,
  output res_t        res
);

  logic [31:0] mask;
  logic [31:0] pv_g;
  logic        g_done;
  logic [31:0] merged_bg;
  logic [31:0] merged_fg;
  logic [17:0] x_sum;
  logic [17:0] y_sum;
  logic        x_more;
  logic        y_more;
  logic        is_last;
  logic [16:0] adv_x;
  logic [16:0] adv_y;
  logic [7:0]  flags;
  logic [31:0] bgv;
  logic        ends;
  logic        do_next;
  logic        bg_fill;
  logic        end_silent;
  logic        skip;
  logic [15:0] zlen;
  logic [15:0] zdec;
  logic [7:0]  sl_dec;

  // Pixel mask and byte gathering.
  always_comb begin
    case (st.px_last)
      2'd0:    mask = 32'h0000_00ff;
      2'd1:    mask = 32'h0000_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    pv_g      = st.partial | (32'(data_byte) << {st.byte_counter[1:0], 3'b000});
    g_done    = (st.byte_counter[1:0] == st.px_last);
    merged_bg = (st.background & ~mask) | (pv_g & mask);
    merged_fg = (st.foreground & ~mask) | (pv_g & mask);
  end

  // Tile position against the rectangle edges.
  always_comb begin
    x_sum   = 18'(st.tile_x) + 18'(st.tile_w);
    y_sum   = 18'(st.tile_y) + 18'(st.tile_h);
    x_more  = x_sum < 18'(st.rect_right);
    y_more  = y_sum < 18'(st.rect_bottom);
    is_last = !x_more && !y_more;
    adv_x   = x_more ? (st.tile_x + 17'(TileSize)) : 17'(st.rect_left);
    adv_y   = x_more ? st.tile_y : (st.tile_y + 17'(TileSize));
  end

  // One parse step per item.
  always_comb begin
    st_nxt     = st;
    res_valid  = 1'b0;
    res        = '0;
    ends       = 1'b0;
    do_next    = 1'b0;
    bg_fill    = 1'b0;
    end_silent = 1'b0;
    skip       = 1'b0;
    flags      = (st.phase == PH_SUBENC) ? data_byte : st.sub_flags;
    bgv        = (st.phase == PH_BG) ? merged_bg : st.background;
    zlen       = {st.partial[15:8], data_byte};
    zdec       = (st.byte_counter != 16'd0) ? (st.byte_counter - 16'd1) : st.byte_counter;
    sl_dec     = st.subrects_left - 8'd1;

    if (op == OP_START) begin
      case (cfg_code)
        PSZ_8:   st_nxt.px_last = 2'd0;
        PSZ_16:  st_nxt.px_last = 2'd1;
        default: st_nxt.px_last = 2'd3;
      endcase
      st_nxt.rect_left    = rect_x;
      st_nxt.rect_right   = 17'(rect_x) + 17'(rect_w);
      st_nxt.rect_bottom  = 17'(rect_y) + 17'(rect_h);
      st_nxt.tile_x       = 17'(rect_x);
      st_nxt.tile_y       = 17'(rect_y);
      st_nxt.byte_counter = '0;
      st_nxt.partial      = '0;
      if (rect_w == 16'd0 || rect_h == 16'd0) begin
        st_nxt.tile_w = '0;
        st_nxt.tile_h = '0;
        st_nxt.phase  = PH_IDLE;
      end else begin
        st_nxt.tile_w = clip_dim(17'(rect_w));
        st_nxt.tile_h = clip_dim(17'(rect_h));
        st_nxt.phase  = PH_SUBENC;
      end
    end else begin
      case (st.phase)
        PH_SUBENC: begin
          st_nxt.sub_flags    = data_byte;
          st_nxt.byte_counter = '0;
          st_nxt.partial      = '0;
          if (data_byte[SE_RAW]) begin
            st_nxt.phase   = PH_RAW;
            st_nxt.pix_col = '0;
            st_nxt.pix_row = '0;
          end else if (data_byte[SE_ZLO] || data_byte[SE_ZHI]) begin
            st_nxt.phase = PH_ZLEN;
          end else if (data_byte[SE_BG]) begin
            st_nxt.phase = PH_BG;
          end else begin
            bg_fill = 1'b1;
          end
        end
        PH_RAW: begin
          st_nxt.partial      = pv_g;
          st_nxt.byte_counter = st.byte_counter + 16'd1;
          if (g_done) begin
            ends      = (5'(st.pix_col) == st.tile_w - 5'd1)
                     && (5'(st.pix_row) == st.tile_h - 5'd1);
            res_valid = 1'b1;
            res.kind  = KIND_PIXEL;
            res.pos_x = st.tile_x[15:0] + 16'(st.pix_col);
            res.pos_y = st.tile_y[15:0] + 16'(st.pix_row);
            res.fill_w = 5'd1;
            res.fill_h = 5'd1;
            res.color  = pv_g & mask;
            res.rect_done = ends && is_last;
            st_nxt.partial      = '0;
            st_nxt.byte_counter = '0;
            if (5'(st.pix_col) == st.tile_w - 5'd1) begin
              st_nxt.pix_col = '0;
              st_nxt.pix_row = st.pix_row + 4'd1;
            end else begin
              st_nxt.pix_col = st.pix_col + 4'd1;
            end
            do_next = ends;
          end
        end
        PH_ZLEN: begin
          if (st.byte_counter == 16'd0) begin
            st_nxt.partial      = {16'd0, data_byte, 8'd0};
            st_nxt.byte_counter = 16'd1;
          end else begin
            st_nxt.byte_counter = zlen;
            st_nxt.partial      = '0;
            if (zlen == 16'd0) begin
              skip = 1'b1;
            end else begin
              st_nxt.phase = PH_ZSKIP;
            end
          end
        end
        PH_ZSKIP: begin
          st_nxt.byte_counter = zdec;
          skip = (zdec == 16'd0);
        end
        PH_BG: begin
          st_nxt.partial      = pv_g;
          st_nxt.byte_counter = st.byte_counter + 16'd1;
          if (g_done) begin
            st_nxt.background = merged_bg;
            bg_fill = 1'b1;
          end
        end
        PH_FG: begin
          st_nxt.partial      = pv_g;
          st_nxt.byte_counter = st.byte_counter + 16'd1;
          if (g_done) begin
            st_nxt.foreground = merged_fg;
            if (st.sub_flags[SE_SUBR]) begin
              st_nxt.phase = PH_COUNT;
            end else begin
              end_silent = 1'b1;
            end
          end
        end
        PH_COUNT: begin
          st_nxt.subrects_left = data_byte;
          if (data_byte == 8'd0) begin
            end_silent = 1'b1;
          end else if (st.sub_flags[SE_COLSR]) begin
            st_nxt.phase        = PH_SCOLOR;
            st_nxt.byte_counter = '0;
            st_nxt.partial      = '0;
          end else begin
            st_nxt.phase = PH_GEO1;
          end
        end
        PH_SCOLOR: begin
          st_nxt.partial      = pv_g;
          st_nxt.byte_counter = st.byte_counter + 16'd1;
          if (g_done) begin
            st_nxt.foreground = merged_fg;
            st_nxt.phase      = PH_GEO1;
          end
        end
        PH_GEO1: begin
          st_nxt.geo   = data_byte;
          st_nxt.phase = PH_GEO2;
        end
        PH_GEO2: begin
          st_nxt.subrects_left = sl_dec;
          ends          = (sl_dec == 8'd0);
          res_valid     = 1'b1;
          res.kind      = KIND_FILL;
          res.pos_x     = st.tile_x[15:0] + 16'(st.geo[7:4]);
          res.pos_y     = st.tile_y[15:0] + 16'(st.geo[3:0]);
          res.fill_w    = 5'(data_byte[7:4]) + 5'd1;
          res.fill_h    = 5'(data_byte[3:0]) + 5'd1;
          res.color     = st.foreground & mask;
          res.rect_done = ends && is_last;
          if (ends) begin
            do_next = 1'b1;
          end else if (st.sub_flags[SE_COLSR]) begin
            st_nxt.phase        = PH_SCOLOR;
            st_nxt.byte_counter = '0;
            st_nxt.partial      = '0;
          end else begin
            st_nxt.phase = PH_GEO1;
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end

    // Background fill, then the foreground or subrects that follow it.
    if (bg_fill) begin
      if (flags[SE_FG]) begin
        st_nxt.phase        = PH_FG;
        st_nxt.byte_counter = '0;
        st_nxt.partial      = '0;
      end else if (flags[SE_SUBR]) begin
        st_nxt.phase = PH_COUNT;
      end else begin
        ends = 1'b1;
      end
      res_valid     = 1'b1;
      res.kind      = KIND_FILL;
      res.pos_x     = st.tile_x[15:0];
      res.pos_y     = st.tile_y[15:0];
      res.fill_w    = st.tile_w;
      res.fill_h    = st.tile_h;
      res.color     = bgv & mask;
      res.rect_done = ends && is_last;
      do_next       = ends;
    end

    // A tile that ends with no command marks the rectangle end if last.
    if (end_silent) begin
      if (is_last) begin
        res_valid     = 1'b1;
        res.kind      = KIND_FILL;
        res.pos_x     = st.tile_x[15:0];
        res.pos_y     = st.tile_y[15:0];
        res.fill_w    = '0;
        res.fill_h    = '0;
        res.color     = '0;
        res.rect_done = 1'b1;
      end
      do_next = 1'b1;
    end

    // Compressed tile skipped.
    if (skip) begin
      res_valid     = 1'b1;
      res.kind      = KIND_SKIP;
      res.pos_x     = st.tile_x[15:0];
      res.pos_y     = st.tile_y[15:0];
      res.fill_w    = st.tile_w;
      res.fill_h    = st.tile_h;
      res.color     = '0;
      res.rect_done = is_last;
      do_next       = 1'b1;
    end

    // Move to the next tile in row-major order.
    if (do_next) begin
      st_nxt.tile_x = adv_x;
      if (x_more || y_more) begin
        st_nxt.tile_y = adv_y;
        st_nxt.tile_w = clip_dim(st.rect_right - adv_x);
        st_nxt.tile_h = clip_dim(st.rect_bottom - adv_y);
        st_nxt.phase  = PH_SUBENC;
      end else begin
        st_nxt.phase = PH_IDLE;
      end
    end
  end

endmodule

/* rtl/hextile_tile_decoder_top.sv */
`timescale 1ns / 1ps

// Hextile rectangle decoder. A start item (op 0) gives a rectangle; the stream
// bytes that follow (op 1) are parsed tile by tile into fill, pixel and
// skipped-tile commands, at most one per item. Every item is registered, parsed
// combinationally and its command lands in the output register, so one item is
// taken per clock while the output is drained. The pixel size register is
// sampled at each rectangle start and should be written only while the block is
// idle.
module hextile_tile_decoder_top import hxt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_pixel_size_code,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_rect_x,
  input  logic [15:0] in_rect_y,
  input  logic [15:0] in_rect_w,
  input  logic [15:0] in_rect_h,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [4:0]  out_fill_w,
  output logic [4:0]  out_fill_h,
  output logic [31:0] out_color,
  output logic        out_rect_done
);

  // Parser state after reset: idle, four-byte pixels, everything else zero.
  localparam st_t StReset = '{phase: PH_IDLE, px_last: 2'd3, default: '0};

  logic [1:0]  psz_r;
  logic        item_v_r;
  logic        op_r;
  logic [15:0] rx_r;
  logic [15:0] ry_r;
  logic [15:0] rw_r;
  logic [15:0] rh_r;
  logic [7:0]  db_r;
  st_t         st_r;
  st_t         st_nxt;
  logic        res_v;
  res_t        res;
  logic        out_valid_r;
  res_t        out_r;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv       = item_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_v_r || adv;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psz_r <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      psz_r <= cfg_pixel_size_code;
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_op;
      rx_r <= in_rect_x;
      ry_r <= in_rect_y;
      rw_r <= in_rect_w;
      rh_r <= in_rect_h;
      db_r <= in_data_byte;
    end
  end

  hxt_parse u_parse (
    .st        (st_r),
    .cfg_code  (psz_r),
    .op        (op_r),
    .rect_x    (rx_r),
    .rect_y    (ry_r),
    .rect_w    (rw_r),
    .rect_h    (rh_r),
    .data_byte (db_r),
    .st_nxt    (st_nxt),
    .res_valid (res_v),
    .res       (res)
  );

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StReset;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (adv && res_v) || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_v) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_r.kind;
  assign out_pos_x     = out_r.pos_x;
  assign out_pos_y     = out_r.pos_y;
  assign out_fill_w    = out_r.fill_w;
  assign out_fill_h    = out_r.fill_h;
  assign out_color     = out_r.color;
  assign out_rect_done = out_r.rect_done;

`ifndef SYNTHESIS
  // A held item with a stalled output must block the input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while parse stage is stalled");

  // A new result only appears after a parse step.
  a_res_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("result appeared without a parse step");

  // Skipped tiles always cover a non-empty tile.
  a_skip_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == KIND_SKIP |-> out_r.fill_w != 5'd0 && out_r.fill_h != 5'd0)
    else $error("skip result with empty tile");
`endif

endmodule
